FILE: rtl/acv_pkg.sv
// Package with the shared constants, codes and types of the archive container validator.
package acv_pkg;

    localparam int OFFSET_BITS = 48;

    localparam logic [31:0] CONTAINER_MAGIC = 32'h0204_5767;
    localparam logic [31:0] MEMBER_MAGIC    = 32'h0104_5767;
    localparam logic [15:0] MEMBER_SIG      = 16'h1231;
    localparam logic [15:0] METHOD_CODE     = 16'h1002;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [7:0]  PRINT_LOW       = 8'h20;
    localparam logic [7:0]  PRINT_HIGH      = 8'h7E;
    localparam logic [16:0] MAX_MEMBERS_RST = 17'd100000;
    localparam logic [15:0] MAX_NAME_RST    = 16'd4096;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_HEADER    = 4'd1,
        ERR_PREFIX    = 4'd2,
        ERR_NAME      = 4'd3,
        ERR_TRAILER   = 4'd4,
        ERR_CRC       = 4'd5,
        ERR_TOTAL     = 4'd6,
        ERR_TRUNCATED = 4'd7,
        ERR_COUNT     = 4'd8,
        ERR_TERM      = 4'd9
    } err_t;

    localparam logic CFG_MAX_MEMBERS = 1'b0;
    localparam logic CFG_MAX_NAME    = 1'b1;

    // One result word, packed into tdata from the lowest bit up.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] archive_length;
        logic [16:0]            member_number;
        logic [15:0]            attribute_bits;
        logic [31:0]            modify_time;
        logic [31:0]            unpacked_size;
        logic [31:0]            packed_size;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [OFFSET_BITS-1:0] header_offset;
        logic [3:0]             error_code;
        logic                   accepted;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/acv_parser.sv
// Byte parser of the archive container validator: all header, member and CRC checks.
module acv_parser
    import acv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_stream,
    input  logic [16:0]            max_members,
    input  logic [15:0]            max_name_length,
    output logic                   rec_valid,
    output result_t                rec,
    output logic                   ver_valid,
    output result_t                ver,
    output logic                   done
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_PREFIX, PH_NAME, PH_TRAILER, PH_PAYLOAD, PH_TERM, PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [31:0]            shift_reg, shift_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [15:0]            name_left_reg, name_left_next;
    logic [31:0]            pay_left_reg, pay_left_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            decl_reg, decl_next;
    logic [32:0]            total_reg, total_next;
    logic [16:0]            seen_reg, seen_next;
    logic [31:0]            mtime_reg, mtime_next;
    logic [15:0]            attr_reg, attr_next;
    logic [31:0]            packed_reg, packed_next;
    logic [31:0]            unpacked_reg, unpacked_next;
    logic [31:0]            crcst_reg, crcst_next;
    logic [OFFSET_BITS-1:0] hoff_reg, hoff_next;
    logic [OFFSET_BITS-1:0] poff_reg, poff_next;

    logic [31:0] gathered;
    logic [1:0]  lane;
    logic [31:0] crc_upd;
    logic [32:0] total_sum;
    logic        fin;
    logic [31:0] fin_crc;
    logic        vflag;
    logic [3:0]  verr;

    assign done    = (phase_reg == PH_DONE);
    assign crc_upd = crc_byte(crc_reg, data_byte);

    always_comb
    begin
        case (phase_reg)
            PH_PREFIX:  lane = (cnt_reg < 6'd4) ? cnt_reg[1:0]
                             : ((cnt_reg < 6'd6) ? 2'(cnt_reg - 6'd4) : 2'(cnt_reg - 6'd6));
            PH_TRAILER: lane = (cnt_reg < 6'd4) ? cnt_reg[1:0]
                             : (cnt_reg < 6'd6) ? 2'(cnt_reg - 6'd4)
                             : (cnt_reg < 6'd10) ? 2'(cnt_reg - 6'd6)
                             : (cnt_reg < 6'd14) ? 2'(cnt_reg - 6'd10)
                             : (cnt_reg < 6'd18) ? 2'(cnt_reg - 6'd14)
                             : (cnt_reg < 6'd22) ? 2'(cnt_reg - 6'd18)
                             : 2'(cnt_reg - 6'd22);
            default:    lane = cnt_reg[1:0];
        endcase
        gathered = ((lane == 2'd0) ? 32'd0 : shift_reg) | ({24'd0, data_byte} << {lane, 3'b000});
    end

    always_comb
    begin
        phase_next    = phase_reg;
        off_next      = off_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        name_left_next = name_left_reg;
        pay_left_next = pay_left_reg;
        crc_next      = crc_reg;
        decl_next     = decl_reg;
        total_next    = total_reg;
        seen_next     = seen_reg;
        mtime_next    = mtime_reg;
        attr_next     = attr_reg;
        packed_next   = packed_reg;
        unpacked_next = unpacked_reg;
        crcst_next    = crcst_reg;
        hoff_next     = hoff_reg;
        poff_next     = poff_reg;
        fin           = 1'b0;
        fin_crc       = crc_reg;
        vflag         = 1'b0;
        verr          = ERR_OK;
        rec_valid     = 1'b0;
        total_sum     = total_reg + {1'b0, unpacked_reg};

        if (step && phase_reg != PH_DONE)
        begin
            if (off_reg == OFF_MAX)
            begin
                vflag = 1'b1;
                verr  = ERR_TRUNCATED;
            end
            else
            begin
                off_next = off_reg + 1'b1;
                case (phase_reg)
                    PH_HEADER:
                    begin
                        shift_next = gathered;
                        cnt_next   = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd3 && gathered != CONTAINER_MAGIC)
                        begin
                            vflag = 1'b1; verr = ERR_HEADER;
                        end
                        if (cnt_reg == 6'd7)
                        begin
                            decl_next = gathered;
                        end
                        if (cnt_reg == 6'd11)
                        begin
                            cnt_next = 6'd0;
                            if (gathered != 32'd0)
                            begin
                                vflag = 1'b1; verr = ERR_HEADER;
                            end
                            else if (seen_reg >= max_members)
                            begin
                                vflag = 1'b1; verr = ERR_COUNT;
                            end
                            else
                            begin
                                phase_next = PH_PREFIX;
                            end
                        end
                    end
                    PH_PREFIX:
                    begin
                        if (cnt_reg == 6'd0)
                        begin
                            hoff_next = off_reg;
                        end
                        shift_next = gathered;
                        cnt_next   = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd3 && gathered != MEMBER_MAGIC)
                        begin
                            vflag = 1'b1; verr = ERR_PREFIX;
                        end
                        if (cnt_reg == 6'd5 && gathered != {16'd0, MEMBER_SIG})
                        begin
                            vflag = 1'b1; verr = ERR_PREFIX;
                        end
                        if (cnt_reg == 6'd7)
                        begin
                            cnt_next = 6'd0;
                            if (gathered[15:0] == 16'd0)
                            begin
                                if (seen_reg == 17'd0)
                                begin
                                    vflag = 1'b1; verr = ERR_TERM;
                                end
                                else if (total_reg != {1'b0, decl_reg})
                                begin
                                    vflag = 1'b1; verr = ERR_TOTAL;
                                end
                                else
                                begin
                                    phase_next = PH_TERM;
                                end
                            end
                            else if (gathered[15:0] > max_name_length)
                            begin
                                vflag = 1'b1; verr = ERR_NAME;
                            end
                            else
                            begin
                                name_left_next = gathered[15:0];
                                phase_next     = PH_NAME;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        if (data_byte < PRINT_LOW || data_byte > PRINT_HIGH)
                        begin
                            vflag = 1'b1; verr = ERR_NAME;
                        end
                        else
                        begin
                            name_left_next = name_left_reg - 16'd1;
                            if (name_left_reg == 16'd1)
                            begin
                                cnt_next   = 6'd0;
                                phase_next = PH_TRAILER;
                            end
                        end
                    end
                    PH_TRAILER:
                    begin
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg < 6'd24)
                        begin
                            shift_next = gathered;
                        end
                        if (cnt_reg == 6'd3)  mtime_next    = gathered;
                        if (cnt_reg == 6'd5)  attr_next     = gathered[15:0];
                        if (cnt_reg == 6'd13) packed_next   = gathered;
                        if (cnt_reg == 6'd17) unpacked_next = gathered;
                        if (cnt_reg == 6'd21) crcst_next    = gathered;
                        if ((cnt_reg == 6'd9 && gathered != 32'd0)
                            || (cnt_reg == 6'd23 && gathered != {16'd0, METHOD_CODE})
                            || (cnt_reg >= 6'd24 && data_byte != 8'd0))
                        begin
                            vflag = 1'b1; verr = ERR_TRAILER;
                        end
                        else if (cnt_reg == 6'd32)
                        begin
                            poff_next     = off_reg + 1'b1;
                            crc_next      = '1;
                            pay_left_next = packed_reg;
                            cnt_next      = 6'd0;
                            if (packed_reg == 32'd0)
                            begin
                                fin     = 1'b1;
                                fin_crc = '1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next      = crc_upd;
                        pay_left_next = pay_left_reg - 32'd1;
                        if (pay_left_reg == 32'd1)
                        begin
                            fin     = 1'b1;
                            fin_crc = crc_upd;
                        end
                    end
                    PH_TERM:
                    begin
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg >= 6'd32)
                        begin
                            vflag = 1'b1; verr = ERR_OK;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Member completion: CRC first, then the running total.
                if (fin)
                begin
                    if (~fin_crc != crcst_reg)
                    begin
                        vflag = 1'b1; verr = ERR_CRC;
                    end
                    else
                    begin
                        total_next = total_sum;
                        if (total_sum > {1'b0, decl_reg})
                        begin
                            vflag = 1'b1; verr = ERR_TOTAL;
                        end
                        else
                        begin
                            rec_valid = 1'b1;
                            seen_next = seen_reg + 17'd1;
                            cnt_next  = 6'd0;
                            if (seen_reg + 17'd1 >= max_members)
                            begin
                                vflag = 1'b1; verr = ERR_COUNT;
                            end
                            else
                            begin
                                phase_next = PH_PREFIX;
                            end
                        end
                    end
                end
            end

            if (!vflag && end_of_stream)
            begin
                vflag = 1'b1; verr = ERR_TRUNCATED;
            end
            if (vflag)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_comb
    begin
        rec                = '0;
        rec.header_offset  = hoff_reg;
        rec.payload_offset = (phase_reg == PH_TRAILER) ? poff_next : poff_reg;
        rec.packed_size    = packed_reg;
        rec.unpacked_size  = unpacked_reg;
        rec.modify_time    = mtime_reg;
        rec.attribute_bits = attr_reg;
        rec.member_number  = seen_reg;

        ver_valid          = vflag;
        ver                = '0;
        ver.accepted       = (verr == ERR_OK);
        ver.error_code     = verr;
        ver.member_number  = seen_next;
        ver.archive_length = (verr == ERR_OK) ? off_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            off_reg       <= '0;
            shift_reg     <= '0;
            cnt_reg       <= '0;
            name_left_reg <= '0;
            pay_left_reg  <= '0;
            crc_reg       <= '1;
            decl_reg      <= '0;
            total_reg     <= '0;
            seen_reg      <= '0;
            mtime_reg     <= '0;
            attr_reg      <= '0;
            packed_reg    <= '0;
            unpacked_reg  <= '0;
            crcst_reg     <= '0;
            hoff_reg      <= '0;
            poff_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            off_reg       <= off_next;
            shift_reg     <= shift_next;
            cnt_reg       <= cnt_next;
            name_left_reg <= name_left_next;
            pay_left_reg  <= pay_left_next;
            crc_reg       <= crc_next;
            decl_reg      <= decl_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            mtime_reg     <= mtime_next;
            attr_reg      <= attr_next;
            packed_reg    <= packed_next;
            unpacked_reg  <= unpacked_next;
            crcst_reg     <= crcst_next;
            hoff_reg      <= hoff_next;
            poff_reg      <= poff_next;
        end
    end

endmodule

FILE: rtl/archive_container_validator.sv
// Top level of the archive container validator: handshakes, result queue and configuration.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: data_byte; tlast: end_of_stream
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: result fields; tuser: result_kind;
//           |           |                        | tlast: last_of_run
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Each input word is parsed in the cycle it is accepted; a new word can be taken every
// cycle. One byte causes at most two result words (a member record and a verdict), which
// go into a four-entry result queue; input is taken while at least two entries are free,
// so a stalled output side only stops the input once the queue is near full.
// Reset clears the parser to the container header phase and the registers to their
// defaults. After a verdict every further byte is taken and dropped.
module archive_container_validator
    import acv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // end_of_stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted, error_code, header_offset, payload_offset, packed_size, unpacked_size,
    // modify_time, attribute_bits, member_number, archive_length, zero fill (low to high)
    output logic [TDATA_BITS-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,   // result_kind
    output logic                  m_axis_tlast,   // last_of_run
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_data
);

    typedef struct packed {
        logic    kind;
        logic    last;
        result_t res;
    } entry_t;

    logic [16:0] max_members_reg;
    logic [15:0] max_name_reg;

    entry_t      q_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;

    logic        step;
    logic        rec_valid, ver_valid, done;
    result_t     rec, ver;
    logic        pop;
    logic [1:0]  pushes;

    assign s_axis_tready = (cnt_reg <= 3'd2);
    assign step          = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    acv_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (s_axis_tdata),
        .end_of_stream   (s_axis_tlast),
        .max_members     (max_members_reg),
        .max_name_length (max_name_reg),
        .rec_valid       (rec_valid),
        .rec             (rec),
        .ver_valid       (ver_valid),
        .ver             (ver),
        .done            (done)
    );

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = TDATA_BITS'(q_reg[rp_reg].res);
    assign m_axis_tuser  = q_reg[rp_reg].kind;
    assign m_axis_tlast  = q_reg[rp_reg].last;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign pushes        = {1'b0, rec_valid} + {1'b0, ver_valid};

    always_ff @(posedge clk)
    begin
        if (rec_valid)
        begin
            q_reg[wp_reg] <= '{kind: 1'b0, last: !ver_valid, res: rec};
        end
        if (ver_valid)
        begin
            q_reg[rec_valid ? wp_reg + 2'd1 : wp_reg] <= '{kind: 1'b1, last: 1'b1, res: ver};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            cnt_reg         <= '0;
            max_members_reg <= MAX_MEMBERS_RST;
            max_name_reg    <= MAX_NAME_RST;
        end
        else
        begin
            wp_reg  <= wp_reg + pushes;
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, pushes} - {2'b00, pop};
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_MEMBERS)
                begin
                    max_members_reg <= cfg_data;
                end
                else
                begin
                    max_name_reg <= cfg_data[15:0];
                end
            end
        end
    end

`ifndef SYNTHESIS
    // The result queue never holds more than its four entries.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("result queue overflow");

    // Once the verdict is out, no further result word is produced.
    assert property (@(posedge clk) disable iff (!rst_n) $past(done) |-> pushes == 2'd0)
        else $error("result after verdict");

    // A verdict word always closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("verdict not last of run");
`endif

endmodule
